[design/nnis_pkg.sv]
// Shared types and constants for the nearest-neighbor image scaler.
`default_nettype none

package nnis_pkg;

    localparam int PIXEL_W    = 24;
    localparam int FACTOR_W   = 7;
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int FACTOR_MAX = 100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_FACTOR = 2'd0,
        CFG_HALVE_MODE   = 2'd1,
        CFG_ROW_WIDTH    = 2'd2
    } cfg_idx_t;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_PULL = 1'b1;

    // Result fields that are known when the item is accepted; the pixel follows from the RAM.
    typedef struct packed {
        logic       accepted;
        logic       has_pixel;
        logic       row_end;
        logic [1:0] pad_bytes;
    } res_meta_t;

endpackage

`default_nettype wire

[design/nnis_ram.sv]
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module nnis_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

[design/nearest_neighbor_image_scaler_unit.sv]
// Nearest-neighbor image scaler: line store, replay counters and result pipeline.
// A result passes through the stage-1 register and the output register before it is on m_valid.
// One item per cycle unless stalled; each unrefused item does one line-store read or write.
// The line-store read latency sets the pipeline stage ahead of the output register.
// Reset (aresetn low, synchronous) clears counters, flags, pipeline valids and halve mode;
// factor and width go to 1. Line-store contents are not cleared; no clearing pass is needed.
`default_nettype none

module nearest_neighbor_image_scaler_unit
    import nnis_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_action,
    input  wire logic [PIXEL_W-1:0]    s_pixel_in,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_accepted,
    output logic                       m_has_pixel,
    output logic [PIXEL_W-1:0]         m_pixel_out,
    output logic                       m_row_end,
    output logic [1:0]                 m_pad_bytes
);

    localparam int ROW_MAX = (1 << ROW_W) - 1;
    localparam int LIM     = (MAX_WIDTH < ROW_MAX) ? MAX_WIDTH : ROW_MAX;
    localparam int CW      = $clog2(LIM + 1);
    localparam int AW      = $clog2(MAX_WIDTH);
    localparam int XW      = ((CW > AW) ? CW : AW) + 1;

    // configuration
    logic [FACTOR_W-1:0] scale_factor_reg;
    logic                halve_mode_reg;
    logic [ROW_W-1:0]    row_width_reg;

    // replay state
    logic [CW-1:0]       fill_count_reg,   fill_count_next;
    logic                row_ready_reg,    row_ready_next;
    logic                odd_row_reg,      odd_row_next;
    logic [CW-1:0]       out_column_reg,   out_column_next;
    logic [FACTOR_W-1:0] pixel_repeat_reg, pixel_repeat_next;
    logic [FACTOR_W-1:0] row_repeat_reg,   row_repeat_next;

    // pipeline
    logic                p1_valid_reg;
    res_meta_t           p1_meta_reg,  p1_meta_next;
    logic                out_valid_reg;
    res_meta_t           out_meta_reg;
    logic [PIXEL_W-1:0]  out_pixel_reg;

    logic                p1_move;
    logic                xfer_in;
    logic                ram_en;
    logic                ram_we;
    logic [XW-1:0]       ram_idx;
    logic [PIXEL_W-1:0]  ram_rdata;

    logic [FACTOR_W-1:0] factor;
    logic [ROW_W:0]      width_sat;
    logic [CW-1:0]       width;
    logic [CW-1:0]       half_width;
    logic [CW-1:0]       fill_inc;
    logic [CW-1:0]       col_inc;
    logic [FACTOR_W-1:0] pix_inc;
    logic [FACTOR_W-1:0] row_inc;
    logic [3:0]          pad_prod;

    // ---------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_factor_reg <= FACTOR_W'(1);
            halve_mode_reg   <= 1'b0;
            row_width_reg    <= ROW_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SCALE_FACTOR: scale_factor_reg <= cfg_wdata[FACTOR_W-1:0];
                CFG_HALVE_MODE:   halve_mode_reg   <= cfg_wdata[0];
                CFG_ROW_WIDTH:    row_width_reg    <= cfg_wdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // effective limits
    always_comb begin
        if (scale_factor_reg == '0) begin
            factor = FACTOR_W'(1);
        end else if (scale_factor_reg > FACTOR_W'(FACTOR_MAX)) begin
            factor = FACTOR_W'(FACTOR_MAX);
        end else begin
            factor = scale_factor_reg;
        end

        if (row_width_reg == '0) begin
            width_sat = (ROW_W+1)'(1);
        end else if ((ROW_W+1)'(row_width_reg) > (ROW_W+1)'(LIM)) begin
            width_sat = (ROW_W+1)'(LIM);
        end else begin
            width_sat = (ROW_W+1)'(row_width_reg);
        end
        width      = width_sat[CW-1:0];
        half_width = width >> 1;
        pad_prod   = {2'b00, width[1:0]} * {2'b00, factor[1:0]};
    end

    // ---------------------------------------------------------------- handshake
    assign p1_move = !out_valid_reg || m_ready;
    assign s_ready = !p1_valid_reg || p1_move;
    assign xfer_in = s_valid && s_ready;

    assign fill_inc = fill_count_reg + CW'(1);
    assign col_inc  = out_column_reg + CW'(1);
    assign pix_inc  = pixel_repeat_reg + FACTOR_W'(1);
    assign row_inc  = row_repeat_reg + FACTOR_W'(1);

    // ---------------------------------------------------------------- item update
    always_comb begin
        fill_count_next   = fill_count_reg;
        row_ready_next    = row_ready_reg;
        odd_row_next      = odd_row_reg;
        out_column_next   = out_column_reg;
        pixel_repeat_next = pixel_repeat_reg;
        row_repeat_next   = row_repeat_reg;
        p1_meta_next      = '0;
        ram_en            = 1'b0;
        ram_we            = 1'b0;
        ram_idx           = XW'(fill_count_reg);

        if (xfer_in) begin
            if (s_action == ACT_PUSH) begin
                if (!row_ready_reg) begin
                    ram_en                = 1'b1;
                    ram_we                = 1'b1;
                    p1_meta_next.accepted = 1'b1;
                    fill_count_next       = fill_inc;
                    if (fill_inc >= width) begin
                        fill_count_next   = '0;
                        out_column_next   = '0;
                        pixel_repeat_next = '0;
                        row_repeat_next   = '0;
                        if (halve_mode_reg) begin
                            // only even rows with a nonempty output are replayed
                            if (!odd_row_reg && half_width != '0) begin
                                row_ready_next = 1'b1;
                            end
                            odd_row_next = !odd_row_reg;
                        end else begin
                            row_ready_next = 1'b1;
                        end
                    end
                end
            end else if (row_ready_reg) begin
                ram_en                 = 1'b1;
                p1_meta_next.has_pixel = 1'b1;
                if (halve_mode_reg) begin
                    if (half_width == '0 || out_column_reg >= half_width) begin
                        ram_idx         = '0;
                        out_column_next = half_width;
                    end else begin
                        ram_idx         = XW'(out_column_reg) << 1;
                        out_column_next = col_inc;
                    end
                    if (out_column_next >= half_width) begin
                        p1_meta_next.row_end   = 1'b1;
                        p1_meta_next.pad_bytes = half_width[1:0];
                        out_column_next        = '0;
                        row_ready_next         = 1'b0;
                    end
                end else begin
                    ram_idx           = XW'(out_column_reg);
                    pixel_repeat_next = pix_inc;
                    if (pix_inc >= factor) begin
                        pixel_repeat_next = '0;
                        out_column_next   = col_inc;
                    end
                    if (out_column_next >= width) begin
                        p1_meta_next.row_end   = 1'b1;
                        p1_meta_next.pad_bytes = pad_prod[1:0];
                        out_column_next        = '0;
                        pixel_repeat_next      = '0;
                        row_repeat_next        = row_inc;
                        if (row_inc >= factor) begin
                            row_repeat_next = '0;
                            row_ready_next  = 1'b0;
                        end
                    end
                end
            end
        end
    end

    nnis_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_idx[AW-1:0]),
        .wdata (s_pixel_in),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg   <= '0;
            row_ready_reg    <= 1'b0;
            odd_row_reg      <= 1'b0;
            out_column_reg   <= '0;
            pixel_repeat_reg <= '0;
            row_repeat_reg   <= '0;
        end else begin
            fill_count_reg   <= fill_count_next;
            row_ready_reg    <= row_ready_next;
            odd_row_reg      <= odd_row_next;
            out_column_reg   <= out_column_next;
            pixel_repeat_reg <= pixel_repeat_next;
            row_repeat_reg   <= row_repeat_next;
        end
    end

    // ---------------------------------------------------------------- result pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (xfer_in) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_move) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_move) begin
                out_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (xfer_in) begin
            p1_meta_reg <= p1_meta_next;
        end
        if (p1_move && p1_valid_reg) begin
            out_meta_reg  <= p1_meta_reg;
            out_pixel_reg <= p1_meta_reg.has_pixel ? ram_rdata : '0;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_accepted  = out_meta_reg.accepted;
    assign m_has_pixel = out_meta_reg.has_pixel;
    assign m_pixel_out = out_pixel_reg;
    assign m_row_end   = out_meta_reg.row_end;
    assign m_pad_bytes = out_meta_reg.pad_bytes;

    // ---------------------------------------------------------------- assertions
    // store is written only while no row is being replayed
    a_no_write_in_replay: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !row_ready_reg)
        else $error("line store written during replay");

    // a stalled stage-1 entry must not be overwritten
    a_p1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !p1_move) |=> (p1_valid_reg && $stable(p1_meta_reg)))
        else $error("stage-1 result lost under backpressure");

    // a result is either a push or a pull answer, never both
    a_meta_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_meta_reg.accepted && out_meta_reg.has_pixel))
        else $error("result marked both accepted and has_pixel");

    // row end or padding only on a produced pixel
    a_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_meta_reg.row_end || out_meta_reg.pad_bytes != 2'd0)
            |-> out_meta_reg.has_pixel)
        else $error("row end or padding without pixel");

    // repeat counters never pass the largest factor
    a_repeat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pixel_repeat_reg < FACTOR_W'(FACTOR_MAX) && row_repeat_reg < FACTOR_W'(FACTOR_MAX))
        else $error("repeat counter out of range");

endmodule

`default_nettype wire

[tb/sv/nearest_neighbor_image_scaler_unit_tb.sv]
// Self-checking testbench for the nearest-neighbor image scaler: line store fill and replay.
`default_nettype none

module nearest_neighbor_image_scaler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nnis_pkg::*;

    localparam int STORE_DEPTH = 2048;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 60;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic               act;
        logic [PIXEL_W-1:0] px;
    } pixel_item_t;

    typedef struct packed {
        logic               accepted;
        logic               has_pixel;
        logic [PIXEL_W-1:0] pixel;
        logic               row_end;
        logic [1:0]         pad;
    } scaled_px_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    cfg_idx_t              cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_action;
    logic [PIXEL_W-1:0]    s_pixel_in;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_accepted;
    logic                  m_has_pixel;
    logic [PIXEL_W-1:0]    m_pixel_out;
    logic                  m_row_end;
    logic [1:0]            m_pad_bytes;

    nearest_neighbor_image_scaler_unit #(.MAX_WIDTH(STORE_DEPTH)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_pixel_in  (s_pixel_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_accepted  (m_accepted),
        .m_has_pixel (m_has_pixel),
        .m_pixel_out (m_pixel_out),
        .m_row_end   (m_row_end),
        .m_pad_bytes (m_pad_bytes)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shadow of the scaler: registers, line store, fill and replay counters.
    logic [PIXEL_W-1:0]  row_copy [0:STORE_DEPTH-1];
    logic [FACTOR_W-1:0] cfg_factor = 7'd1;
    logic                cfg_halve  = 1'b0;
    logic [ROW_W-1:0]    cfg_width  = 12'd1;
    int                  fill_cnt   = 0;
    bit                  row_rdy    = 1'b0;
    bit                  odd_rw     = 1'b0;
    int                  out_col    = 0;
    int                  pix_rep    = 0;
    int                  row_rep    = 0;
    int                  written_depth = 0;

    pixel_item_t items_todo [$];
    scaled_px_t  scaler_outputs_due [$];
    pixel_item_t drv_item;
    scaled_px_t  mon_got;
    scaled_px_t  mon_want;

    bit in_fire = 1'b0;
    bit hold_go = 1'b0;
    bit hold_off;
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int rand_items = 0;
    int cycle_cnt = 0;
    int src_pct  [4] = '{0, 75, 0, 28};
    int sink_pct [4] = '{0, 0, 75, 28};

    function automatic int eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > STORE_DEPTH) return STORE_DEPTH;
        return int'(cfg_width);
    endfunction

    function automatic int eff_factor();
        if (cfg_factor == 0) return 1;
        if (cfg_factor > FACTOR_MAX) return FACTOR_MAX;
        return int'(cfg_factor);
    endfunction

    function automatic logic [PIXEL_W-1:0] row_copy_at(int idx);
        return (idx < STORE_DEPTH) ? row_copy[idx] : row_copy[0];
    endfunction

    function automatic scaled_px_t next_scaler_output(logic act, logic [PIXEL_W-1:0] px);
        int w;
        int f;
        int ow;
        scaled_px_t r;
        w = eff_width();
        f = eff_factor();
        r = '0;
        if (act == ACT_PUSH) begin
            if (row_rdy) return r;
            if (fill_cnt < STORE_DEPTH) begin
                row_copy[fill_cnt] = px;
                if (fill_cnt + 1 > written_depth) written_depth = fill_cnt + 1;
            end
            fill_cnt++;
            r.accepted = 1'b1;
            if (fill_cnt >= w) begin
                fill_cnt = 0;
                out_col = 0;
                pix_rep = 0;
                row_rep = 0;
                if (cfg_halve) begin
                    if (!odd_rw && (w / 2) > 0) row_rdy = 1'b1;
                    odd_rw = !odd_rw;
                end else begin
                    row_rdy = 1'b1;
                end
            end
            return r;
        end
        if (!row_rdy) return r;
        r.has_pixel = 1'b1;
        if (cfg_halve) begin
            ow = w / 2;
            if (ow == 0 || out_col >= ow) begin
                r.pixel = row_copy_at(0);
                out_col = ow;
            end else begin
                r.pixel = row_copy_at(2 * out_col);
                out_col++;
            end
            if (out_col >= ow) begin
                r.row_end = 1'b1;
                r.pad = 2'(ow % 4);
                out_col = 0;
                row_rdy = 1'b0;
            end
            return r;
        end
        r.pixel = row_copy_at(out_col);
        pix_rep++;
        if (pix_rep >= f) begin
            pix_rep = 0;
            out_col++;
        end
        if (out_col >= w) begin
            r.row_end = 1'b1;
            r.pad = 2'((w * f) % 4);
            out_col = 0;
            pix_rep = 0;
            row_rep++;
            if (row_rep >= f) begin
                row_rep = 0;
                row_rdy = 1'b0;
            end
        end
        return r;
    endfunction

    // Input side: register writes and accepted items go through the shadow.
    always @(posedge aclk) begin
        in_fire = 1'b0;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_SCALE_FACTOR: cfg_factor = cfg_wdata[FACTOR_W-1:0];
                    CFG_HALVE_MODE:   cfg_halve  = cfg_wdata[0];
                    CFG_ROW_WIDTH:    cfg_width  = cfg_wdata[ROW_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                in_fire = 1'b1;
                scaler_outputs_due.push_back(next_scaler_output(s_action, s_pixel_in));
            end
        end
    end

    task automatic log_mismatch(string what, scaled_px_t want, scaled_px_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%s: exp acc=%0d has=%0d px=%06h end=%0d pad=%0d",
                      " | got acc=%0d has=%0d px=%06h end=%0d pad=%0d"},
                     what, want.accepted, want.has_pixel, want.pixel, want.row_end, want.pad,
                     got.accepted, got.has_pixel, got.pixel, got.row_end, got.pad);
    endtask

    // Output side.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            mon_got = '{m_accepted, m_has_pixel, m_pixel_out, m_row_end, m_pad_bytes};
            if (scaler_outputs_due.size() == 0) begin
                log_mismatch("unexpected transfer", '0, mon_got);
            end else begin
                mon_want = scaler_outputs_due.pop_front();
                if (mon_got !== mon_want) log_mismatch("mismatch", mon_want, mon_got);
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (items_todo.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                drv_item = items_todo.pop_front();
                s_action   <= drv_item.act;
                s_pixel_in <= drv_item.px;
                s_valid    <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
    end

    // Long receiver hold-off so the pipeline backs up into the input.
    initial begin
        hold_off = 1'b0;
        wait (hold_go);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        hold_off <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic add_item(logic act, logic [PIXEL_W-1:0] px);
        items_todo.push_back('{act, px});
    endtask

    task automatic wait_idle();
        do begin
            @(negedge aclk);
            #1;
        end while (items_todo.size() != 0 || s_valid || scaler_outputs_due.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // A replay in progress must never be stretched over entries not yet written.
    task automatic set_config(int factor, int halve, int width);
        int weff;
        weff = (width == 0) ? 1 : ((width > STORE_DEPTH) ? STORE_DEPTH : width);
        if (row_rdy && weff > written_depth) width = written_depth;
        write_reg(CFG_SCALE_FACTOR, factor);
        write_reg(CFG_HALVE_MODE, halve);
        write_reg(CFG_ROW_WIDTH, width);
    endtask

    // Whole rows: fill, then just enough pulls to replay them. Noise adds refused
    // transfers and now and then cuts a fill or a replay short.
    task automatic queue_rows(int n_rows, int noise, bit counted);
        int w;
        int f;
        int ow;
        int n_pull;
        int cut;
        bit odd;
        w = eff_width();
        f = eff_factor();
        ow = w / 2;
        odd = odd_rw;
        if (row_rdy) repeat (cfg_halve ? ow : w * f * f) add_item(ACT_PULL, '0);
        for (int r = 0; r < n_rows; r++) begin
            cut = ($urandom_range(99) < noise / 3) ? $urandom_range(1, w) : w;
            for (int i = 0; i < cut; i++) begin
                if ($urandom_range(99) < noise) add_item(ACT_PULL, 24'($urandom()));
                add_item(ACT_PUSH, 24'($urandom()));
                if (counted) rand_items++;
            end
            n_pull = cfg_halve ? (odd ? 0 : ow) : w * f * f;
            if (cfg_halve) odd = !odd;
            if (n_pull > 0 && $urandom_range(99) < noise / 3) n_pull = $urandom_range(1, n_pull);
            for (int j = 0; j < n_pull; j++) begin
                if ($urandom_range(99) < noise) add_item(ACT_PUSH, 24'($urandom()));
                add_item(ACT_PULL, 24'($urandom()));
                if (counted) rand_items++;
            end
        end
    endtask

    initial begin
        int f_new;
        int w_new;
        int h_new;
        int r;
        int phase_start;
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_addr   = CFG_SCALE_FACTOR;
        cfg_wdata  = '0;
        s_valid    = 1'b0;
        s_action   = ACT_PUSH;
        s_pixel_in = '0;
        m_ready    = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: factor 1, width 1. Refused pull, refused push, extremes.
        add_item(ACT_PULL, 24'hFFFFFF);
        add_item(ACT_PUSH, 24'h000000);
        add_item(ACT_PUSH, 24'hFFFFFF);
        add_item(ACT_PULL, 24'h000000);
        add_item(ACT_PULL, 24'h000000);
        add_item(ACT_PUSH, 24'hFFFFFF);
        add_item(ACT_PULL, 24'h000000);
        add_item(ACT_PUSH, 24'hA5A5A5);
        add_item(ACT_PULL, 24'h5A5A5A);
        wait_idle();

        // Zero factor and zero width both act as 1.
        set_config(0, 0, 0);
        add_item(ACT_PUSH, 24'h5A5A5A);
        add_item(ACT_PULL, 24'h000000);
        wait_idle();
        set_config(3, 0, 2);
        queue_rows(1, 0, 0);
        wait_idle();

        // Halve with output width zero: rows taken, never replayed.
        set_config(1, 1, 1);
        queue_rows(2, 0, 0);
        add_item(ACT_PULL, 24'h000000);
        wait_idle();
        // Odd width in halve mode drops the last column; odd rows are discarded.
        set_config(1, 1, 5);
        queue_rows(2, 0, 0);
        add_item(ACT_PULL, 24'h000000);
        wait_idle();

        // Width shrunk in the middle of a replay.
        set_config(2, 0, 4);
        repeat (4) add_item(ACT_PUSH, 24'($urandom()));
        repeat (5) add_item(ACT_PULL, 24'h000000);
        wait_idle();
        set_config(2, 0, 2);
        repeat (6) add_item(ACT_PULL, 24'h000000);
        wait_idle();
        // Width shrunk below a partial fill: the next push closes the row.
        set_config(2, 0, 6);
        repeat (3) add_item(ACT_PUSH, 24'($urandom()));
        wait_idle();
        set_config(2, 0, 2);
        add_item(ACT_PUSH, 24'($urandom()));
        repeat (8) add_item(ACT_PULL, 24'h000000);
        wait_idle();

        // Factor above 100: the first replayed row ends at the 100th pull;
        // dropping the factor to 1 then ends the replay at once.
        set_config(127, 0, 1);
        add_item(ACT_PUSH, 24'($urandom()));
        repeat (103) add_item(ACT_PULL, 24'h000000);
        wait_idle();
        set_config(1, 0, 1);
        repeat (2) add_item(ACT_PULL, 24'h000000);
        wait_idle();
        // Width above the store keeps a short fill open until the width shrinks.
        set_config(1, 0, 4095);
        repeat (5) add_item(ACT_PUSH, 24'($urandom()));
        wait_idle();
        set_config(1, 0, 3);
        add_item(ACT_PUSH, 24'($urandom()));
        repeat (3) add_item(ACT_PULL, 24'h000000);
        wait_idle();

        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = src_pct[p];
            sink_stall_pct = sink_pct[p];
            phase_start = rand_items;
            while (rand_items - phase_start < PHASE_ITEMS) begin
                h_new = ($urandom_range(99) < 35);
                r = $urandom_range(99);
                if (r < 6) f_new = 0;
                else if (r < 16) f_new = $urandom_range(6, 10);
                else f_new = $urandom_range(1, 5);
                if (h_new) w_new = $urandom_range(0, 24);
                else if (f_new >= 6) w_new = $urandom_range(0, 2);
                else if (f_new >= 3) w_new = $urandom_range(1, 6);
                else w_new = $urandom_range(0, 24);
                set_config(f_new, h_new, w_new);
                queue_rows($urandom_range(1, 3), 15, 1'b1);
                if (p == 0) hold_go = 1'b1;
                wait_idle();
            end
        end

        wait_idle();
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0 && scaler_outputs_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
design/nnis_pkg.sv
design/nnis_ram.sv
design/nearest_neighbor_image_scaler_unit.sv
tb/sv/nearest_neighbor_image_scaler_unit_tb.sv
